// ===== rtl/core/lurt_pkg.sv =====
// Package for the longest unique run tracker.
// Holds field widths, parameter defaults and the transaction payload types.
// No dependencies.
package lurt_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W = 16;

  localparam int LURT_MAX_LEN = 65535;
  localparam int LURT_SYMBOL_COUNT = 256;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] best_length;
    logic [POS_W-1:0] window_length;
    logic             length_overflow;
    logic             string_done;
  } out_item_t;

endpackage

// ===== rtl/core/lurt_if.sv =====
// Valid/ready channel interfaces for the longest unique run tracker.
// Depends on lurt_pkg for the payload types.
interface lurt_in_if;
  logic               valid;
  logic               ready;
  lurt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lurt_out_if;
  logic                valid;
  logic                ready;
  lurt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/longest_unique_run_tracker.sv =====
// Longest unique run tracker: one result per input byte, registered in the s1 stage and then in
// the output register, one byte per cycle sustained while the output is not stalled. The
// last-seen table is a SYMBOL_COUNT-entry memory with a registered read, so each byte does a read
// at accept and a write at commit, with one-entry forwarding between the two.
// Reset clears the control state and the per-symbol valid bits; the table is not
// swept, and the valid bits are also cleared at the end of every string.
module longest_unique_run_tracker #(
  parameter int MAX_LEN = lurt_pkg::LURT_MAX_LEN,
  parameter int SYMBOL_COUNT = lurt_pkg::LURT_SYMBOL_COUNT
) (
  input logic       clk,
  input logic       rst_n,
  lurt_in_if.sink   in_chan,
  lurt_out_if.source out_chan
);
  import lurt_pkg::*;

  localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  logic [SYM_W-1:0] fold_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_fold
    assign fold_tab[g] = SYM_W'(g % SYMBOL_COUNT);
  end

  logic [POS_W-1:0] mem [SYMBOL_COUNT];
  logic [POS_W-1:0] rd_data_r;
  logic [SYMBOL_COUNT-1:0] seen_vld_r;

  logic             s1_valid_r;
  logic [SYM_W-1:0] s1_sym_r;
  logic             s1_last_r;
  logic             fwd_hit_r;
  logic [POS_W-1:0] fwd_data_r;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] ws_r;
  logic [POS_W-1:0] best_r;
  logic             ovf_r;

  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             out_free;
  logic             commit;
  logic             in_take;
  logic [SYM_W-1:0] in_sym;
  logic             ovf_now;
  logic             wr_en;
  logic [POS_W-1:0] wr_data;
  logic [POS_W-1:0] entry;
  logic [POS_W-1:0] seen;
  logic [POS_W-1:0] ws_nxt;
  logic [POS_W-1:0] win;
  logic [POS_W-1:0] best_nxt;
  out_item_t        out_data_nxt;

  assign out_free = !out_valid_r || out_chan.ready;
  assign commit = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || commit;
  assign in_take = in_chan.valid && in_chan.ready;
  assign in_sym = fold_tab[in_chan.data.byte_in];

  assign ovf_now = pos_r >= MAX_POS;
  assign entry = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign seen = seen_vld_r[s1_sym_r] ? entry : '0;
  assign ws_nxt = (seen > ws_r) ? seen : ws_r;
  assign wr_data = pos_r + POS_W'(1);
  assign wr_en = commit && !ovf_now;

  always_comb begin
    if (ovf_now) begin
      win = pos_r - ws_r;
      best_nxt = best_r;
    end else begin
      win = wr_data - ws_nxt;
      best_nxt = (win > best_r) ? win : best_r;
    end
    out_data_nxt.best_length = best_nxt;
    out_data_nxt.window_length = win;
    out_data_nxt.length_overflow = ovf_r || ovf_now;
    out_data_nxt.string_done = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_sym_r] <= wr_data;
    end
    if (in_take) begin
      rd_data_r <= mem[in_sym];
      s1_sym_r <= in_sym;
      s1_last_r <= in_chan.data.end_of_string;
      fwd_data_r <= wr_data;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
      out_valid_r <= 1'b0;
      seen_vld_r <= '0;
      pos_r <= '0;
      ws_r <= '0;
      best_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r <= wr_en && (s1_sym_r == in_sym);
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end

      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (commit) begin
        if (s1_last_r) begin
          seen_vld_r <= '0;
          pos_r <= '0;
          ws_r <= '0;
          best_r <= '0;
          ovf_r <= 1'b0;
        end else if (ovf_now) begin
          ovf_r <= 1'b1;
        end else begin
          seen_vld_r[s1_sym_r] <= 1'b1;
          pos_r <= wr_data;
          ws_r <= ws_nxt;
          best_r <= best_nxt;
        end
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data = out_data_r;

  a_win_le_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.window_length <= out_data_r.best_length))
    else $error("window length exceeds best length");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= MAX_POS) && (ws_r <= pos_r))
    else $error("position or window start out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && s1_last_r) |=> ((pos_r == '0) && (seen_vld_r == '0) && !ovf_r))
    else $error("string state not cleared after end of string");

endmodule
